### rtl/sfc_pkg.sv
// Shared types and constants for the sensor frame checksum parser.
// No dependencies; imported by the top level and its port checker.
package sfc_pkg;

    // Event codes carried on the input channel
    typedef enum logic [1:0] {
        CMD_RX_BYTE = 2'd0,
        CMD_IDLE    = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_LOCK    = 2'd3
    } command_t;

    // Frame classification reported with each result
    typedef enum logic [1:0] {
        KIND_DISTANCE = 2'd0,
        KIND_LINE     = 2'd1,
        KIND_OTHER    = 2'd2
    } frame_kind_t;

    // Car modes
    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_AVOID  = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_PATH   = 2'd3
    } drive_mode_t;

    localparam int unsigned   FRAME_BYTES      = 4;
    localparam logic [7:0]    HDR_DISTANCE     = 8'hFF;
    localparam logic [7:0]    HDR_LINE         = 8'hAA;
    localparam logic [15:0]   LOCKOUT_RESET    = 16'd500;
    localparam logic [15:0]   MS_MAX           = 16'hFFFF;
    localparam logic [7:0]    NIBBLE_NONE      = 8'hFF;
    localparam logic [3:0]    NIB_MANUAL       = 4'h0;
    localparam logic [3:0]    NIB_AVOID        = 4'hD;
    localparam logic [3:0]    NIB_LINE         = 4'hF;
    localparam logic [3:0]    NIB_PATH         = 4'hE;

    // Map a mode request nibble to a mode; unknown nibbles keep the current one
    function automatic drive_mode_t nibble_to_mode(input logic [3:0] nib,
                                                   input drive_mode_t cur);
        drive_mode_t m;
        begin
            case (nib)
                NIB_MANUAL: m = MODE_MANUAL;
                NIB_AVOID:  m = MODE_AVOID;
                NIB_LINE:   m = MODE_LINE;
                NIB_PATH:   m = MODE_PATH;
                default:    m = cur;
            endcase
            return m;
        end
    endfunction

endpackage

### rtl/sensor_frame_checksum_parser.sv
// A line-idle event gives its result in the cycle after its transfer; other events give
// no result. Events are taken one per cycle, but for the idle stall below; the frame store
// and mode registers update between the input port and the result register.
// An idle event waits only while a previous result is held and not taken in that cycle.
// Reset (rst_n, asynchronous, active low) clears the frame store, counters and mode,
// sets the lockout to 500 ms and the last mode nibble to none seen.
// Depends on sfc_pkg.
module sensor_frame_checksum_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] lockout_ms,
    // input event channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_ok,
    output logic [1:0]  frame_kind,
    output logic [15:0] distance,
    output logic [7:0]  line_bits,
    output logic [7:0]  line_type,
    output logic [1:0]  drive_mode,
    output logic        mode_changed
);
    import sfc_pkg::*;

    logic [7:0]  frame_store_reg [FRAME_BYTES];
    logic [2:0]  byte_count_reg;
    logic [7:0]  last_nibble_reg, last_nibble_next;
    logic [15:0] ms_since_lock_reg;
    logic [15:0] lockout_reg;
    drive_mode_t mode_reg, mode_next;
    logic [15:0] distance_reg, distance_next;
    logic [7:0]  line_bits_reg, line_bits_next;
    logic [7:0]  line_type_reg, line_type_next;

    logic        out_valid_reg;
    logic        frame_ok_reg, frame_ok_next;
    frame_kind_t frame_kind_reg, frame_kind_next;
    logic        mode_changed_reg, mode_changed_next;

    command_t    cmd;
    logic        in_xfer;
    logic        idle_xfer;
    logic [7:0]  sum;
    logic [3:0]  nib;

    assign cmd       = command_t'(command);
    assign cfg_ready = 1'b1;
    // An idle event needs the result slot; every other event may pass a held result
    assign in_ready  = !out_valid_reg || out_ready || (cmd != CMD_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign idle_xfer = in_xfer && (cmd == CMD_IDLE);

    // Evaluate the frame on line idle
    assign sum = frame_store_reg[0] + frame_store_reg[1] + frame_store_reg[2];
    assign nib = frame_store_reg[2][7:4];

    always_comb
    begin
        frame_ok_next     = 1'b0;
        frame_kind_next   = KIND_OTHER;
        mode_changed_next = 1'b0;
        distance_next     = distance_reg;
        line_bits_next    = line_bits_reg;
        line_type_next    = line_type_reg;
        mode_next         = mode_reg;
        last_nibble_next  = last_nibble_reg;
        if (sum == frame_store_reg[3])
        begin
            frame_ok_next = 1'b1;
            if (frame_store_reg[0] == HDR_DISTANCE)
            begin
                frame_kind_next = KIND_DISTANCE;
                distance_next   = {frame_store_reg[1], frame_store_reg[2]};
            end
            else if (frame_store_reg[0] == HDR_LINE)
            begin
                frame_kind_next = KIND_LINE;
                line_bits_next  = frame_store_reg[1];
                line_type_next  = frame_store_reg[2];
                if ((ms_since_lock_reg > lockout_reg) && ({4'h0, nib} != last_nibble_reg))
                begin
                    mode_next         = nibble_to_mode(nib, mode_reg);
                    last_nibble_next  = {4'h0, nib};
                    mode_changed_next = 1'b1;
                end
            end
        end
    end

    // Lockout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lockout_reg <= LOCKOUT_RESET;
        else if (cfg_valid && cfg_ready)
            lockout_reg <= lockout_ms;
    end

    // Frame store: fill on received bytes, drop bytes past the fourth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_store_reg[i] <= 8'h00;
            byte_count_reg <= 3'd0;
        end
        else if (in_xfer)
        begin
            if (cmd == CMD_RX_BYTE && byte_count_reg < 3'(FRAME_BYTES))
            begin
                frame_store_reg[byte_count_reg[1:0]] <= rx_byte;
                byte_count_reg <= byte_count_reg + 3'd1;
            end
            else if (cmd == CMD_IDLE)
                byte_count_reg <= 3'd0;
        end
    end

    // Millisecond counter since the last remote lock, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ms_since_lock_reg <= 16'd0;
        else if (in_xfer)
        begin
            if (cmd == CMD_LOCK)
                ms_since_lock_reg <= 16'd0;
            else if (cmd == CMD_TICK && ms_since_lock_reg != MS_MAX)
                ms_since_lock_reg <= ms_since_lock_reg + 16'd1;
        end
    end

    // Latest decoded values and mode, updated per frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_reg    <= 16'd0;
            line_bits_reg   <= 8'd0;
            line_type_reg   <= 8'd0;
            mode_reg        <= MODE_MANUAL;
            last_nibble_reg <= NIBBLE_NONE;
        end
        else if (idle_xfer)
        begin
            distance_reg    <= distance_next;
            line_bits_reg   <= line_bits_next;
            line_type_reg   <= line_type_next;
            mode_reg        <= mode_next;
            last_nibble_reg <= last_nibble_next;
        end
    end

    // Result register: load on idle transfer, drop on output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (idle_xfer)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (idle_xfer)
        begin
            frame_ok_reg     <= frame_ok_next;
            frame_kind_reg   <= frame_kind_next;
            mode_changed_reg <= mode_changed_next;
        end
    end

    // Decoded registers change only on idle transfers, so they hold with the result
    assign out_valid    = out_valid_reg;
    assign frame_ok     = frame_ok_reg;
    assign frame_kind   = frame_kind_reg;
    assign mode_changed = mode_changed_reg;
    assign distance     = distance_reg;
    assign line_bits    = line_bits_reg;
    assign line_type    = line_type_reg;
    assign drive_mode   = mode_reg;

endmodule

### rtl/sfc_port_checker.sv
// Port-level checks for the sensor frame checksum parser, bound to the top level.
// Depends on sfc_pkg and sensor_frame_checksum_parser.
module sfc_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  command,
    input logic        out_valid,
    input logic        out_ready,
    input logic        frame_ok,
    input logic [1:0]  frame_kind,
    input logic [1:0]  drive_mode,
    input logic        mode_changed
);
    import sfc_pkg::*;

    // A held result stays until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Every idle transfer shows a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_IDLE) |=> out_valid)
        else $error("idle transfer produced no result");

    // Bad checksum frames are always classed as other
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_ok |-> frame_kind == KIND_OTHER)
        else $error("failed frame reported with a header kind");

    // A mode request is only taken from an accepted line frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_changed |-> frame_ok && frame_kind == KIND_LINE)
        else $error("mode change outside an accepted line frame");

    // The mode moves only on a result that takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        drive_mode != $past(drive_mode) |-> out_valid && mode_changed)
        else $error("drive mode moved without a mode request");

endmodule

bind sensor_frame_checksum_parser sfc_port_checker u_sfc_port_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_ok     (frame_ok),
    .frame_kind   (frame_kind),
    .drive_mode   (drive_mode),
    .mode_changed (mode_changed)
);
